// File: src/ctq_pkg.sv
`default_nettype none
package ctq_pkg;

    localparam int MAX_DIM   = 64;
    localparam int FRAC_BITS = 16;
    localparam int IDX_W     = $clog2(MAX_DIM);
    localparam int DIM_W     = IDX_W + 1;
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int DATA_W    = 32;
    localparam int ACC_W     = 64;

    typedef enum logic [1:0] {
        OP_LOAD_K  = 2'd0,
        OP_LOAD_Q  = 2'd1,
        OP_COMPUTE = 2'd2,
        OP_NONE    = 2'd3
    } ctq_op_t;

    typedef enum logic {
        REG_DIM_N = 1'b0,
        REG_DIM_M = 1'b1
    } ctq_reg_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_OUTWAIT
    } ctq_state_t;

    // phase 0: temp = K^T q_j, phase 1: X[j][i] = temp . q_i
    typedef struct packed {
        logic             load_k;
        logic             load_q;
        logic             issue;
        logic             phase;
        logic             first;
        logic             last_term;
        logic [IDX_W-1:0] k;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
        logic             last_col;
    } ctq_cmd_t;

    typedef struct packed {
        logic sum_done;
        logic out_busy;
    } ctq_stat_t;

    function automatic logic [DATA_W-1:0] scale_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] sh;
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        begin
            sh = acc >>> FRAC_BITS;
            hi = $signed({{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}});
            lo = $signed({{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}});
            if (sh > hi)
                scale_sat = {1'b0, {(DATA_W-1){1'b1}}};
            else if (sh < lo)
                scale_sat = {1'b1, {(DATA_W-1){1'b0}}};
            else
                scale_sat = sh[DATA_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

// File: src/ctq_if.sv
`default_nettype none
interface ctq_in_if;
    import ctq_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [1:0]               operation;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output operation, output row, output col, output value,
                    input ready);
    modport sink   (input valid, input operation, input row, input col, input value,
                    output ready);
endinterface

interface ctq_out_if;
    import ctq_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic signed [DATA_W-1:0] out_value;
    logic                     last;

    modport source (output valid, output out_row, output out_col, output out_value,
                    output last, input ready);
    modport sink   (input valid, input out_row, input out_col, input out_value,
                    input last, output ready);
endinterface
`default_nettype wire

// File: src/ctq_ctrl.sv
`default_nettype none
module ctq_ctrl
    import ctq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] in_operation,
    input  wire logic [IDX_W-1:0] in_row,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [DIM_W-1:0] cfg_data,
    input  wire ctq_stat_t  stat,
    output ctq_cmd_t        cmd
);

    ctq_state_t       state_reg, state_next;
    logic [DIM_W-1:0] dim_n_reg, dim_m_reg;
    logic [DIM_W-1:0] n_reg, n_next, m_reg, m_next;
    logic [IDX_W-1:0] k_reg, k_next, i_reg, i_next, j_reg, j_next;
    logic             phase_reg, phase_next;
    logic [DIM_W-1:0] n_eff, m_eff;
    logic             accept;
    logic             k_end, i_end_n, i_end_m;

    // clamp to 1..MAX_DIM
    always_comb
    begin
        n_eff = (dim_n_reg == '0) ? DIM_W'(1) :
                (dim_n_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : dim_n_reg;
        m_eff = (dim_m_reg == '0) ? DIM_W'(1) :
                (dim_m_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : dim_m_reg;
    end

    assign accept  = in_valid && in_ready;
    assign k_end   = ({1'b0, k_reg} == n_reg - DIM_W'(1));
    assign i_end_n = ({1'b0, i_reg} == n_reg - DIM_W'(1));
    assign i_end_m = ({1'b0, i_reg} == m_reg - DIM_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_n_reg <= DIM_W'(1);
            dim_m_reg <= DIM_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (ctq_reg_t'(cfg_index))
                REG_DIM_N: dim_n_reg <= cfg_data;
                REG_DIM_M: dim_m_reg <= cfg_data;
                default:   dim_n_reg <= dim_n_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_reg     <= DIM_W'(1);
            m_reg     <= DIM_W'(1);
            k_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            m_reg     <= m_next;
            k_reg     <= k_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            phase_reg <= phase_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        m_next     = m_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && ctq_op_t'(in_operation) == OP_COMPUTE
                    && {1'b0, in_row} < m_eff)
                begin
                    state_next = S_ISSUE;
                    n_next     = n_eff;
                    m_next     = m_eff;
                    j_next     = in_row;
                    i_next     = '0;
                    k_next     = '0;
                    phase_next = 1'b0;
                end
            end
            S_ISSUE:
            begin
                k_next = k_reg + IDX_W'(1);
                if (k_end)
                begin
                    k_next     = '0;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (stat.sum_done)
                begin
                    if (!phase_reg)
                    begin
                        if (i_end_n)
                        begin
                            phase_next = 1'b1;
                            i_next     = '0;
                            state_next = S_OUTWAIT;
                        end
                        else
                        begin
                            i_next     = i_reg + IDX_W'(1);
                            state_next = S_ISSUE;
                        end
                    end
                    else if (i_end_m)
                        state_next = S_IDLE;
                    else
                    begin
                        i_next     = i_reg + IDX_W'(1);
                        state_next = S_OUTWAIT;
                    end
                end
            end
            S_OUTWAIT:
            begin
                if (!stat.out_busy)
                    state_next = S_ISSUE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready      = (state_reg == S_IDLE);
        cmd           = '0;
        cmd.load_k    = accept && ctq_op_t'(in_operation) == OP_LOAD_K;
        cmd.load_q    = accept && ctq_op_t'(in_operation) == OP_LOAD_Q;
        cmd.phase     = phase_reg;
        cmd.k         = k_reg;
        cmd.i         = i_reg;
        cmd.j         = j_reg;
        cmd.last_col  = i_end_m;
        unique case (state_reg)
            S_ISSUE:
            begin
                cmd.issue     = 1'b1;
                cmd.first     = (k_reg == '0);
                cmd.last_term = k_end;
            end
            default: cmd.issue = 1'b0;
        endcase
    end

    a_issue_state: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> state_reg == S_ISSUE)
        else $error("issue outside issue state");
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        stat.sum_done |-> state_reg == S_WAIT)
        else $error("sum finished while not waiting");
    a_dims_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> n_reg != '0 && m_reg != '0
            && n_reg <= DIM_W'(MAX_DIM) && m_reg <= DIM_W'(MAX_DIM))
        else $error("latched dimension out of range");

endmodule
`default_nettype wire

// File: src/ctq_dp.sv
`default_nettype none
module ctq_dp
    import ctq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ctq_cmd_t          cmd,
    input  wire logic [IDX_W-1:0]  ld_row,
    input  wire logic [IDX_W-1:0]  ld_col,
    input  wire logic [DATA_W-1:0] ld_value,
    output ctq_stat_t              stat,
    ctq_out_if.source              out_ch
);

    logic [DATA_W-1:0] k_mem [MAX_DIM*MAX_DIM];
    logic [DATA_W-1:0] q_mem [MAX_DIM*MAX_DIM];
    logic [DATA_W-1:0] t_mem [MAX_DIM];

    logic [DATA_W-1:0] k_rd_reg, q_rd_reg, t_rd_reg;
    logic              s1_valid_reg, s1_phase_reg, s1_first_reg, s1_last_reg;
    logic              s2_valid_reg, s2_first_reg, s2_last_reg;
    logic              s3_done_reg;
    logic signed [ACC_W-1:0] prod_reg, acc_reg;
    logic [DATA_W-1:0] sat;
    logic [DATA_W-1:0] mul_a;
    logic [ADDR_W-1:0] ld_addr, k_addr, q_addr;

    logic              out_valid_reg, out_last_reg;
    logic [IDX_W-1:0]  out_row_reg, out_col_reg;
    logic [DATA_W-1:0] out_value_reg;

    assign ld_addr = {ld_row, ld_col};
    assign k_addr  = {cmd.k, cmd.i};
    assign q_addr  = {cmd.k, cmd.phase ? cmd.i : cmd.j};

    always_ff @(posedge clk)
    begin
        if (cmd.load_k)
            k_mem[ld_addr] <= ld_value;
        if (cmd.issue)
            k_rd_reg <= k_mem[k_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_q)
            q_mem[ld_addr] <= ld_value;
        if (cmd.issue)
            q_rd_reg <= q_mem[q_addr];
    end

    always_ff @(posedge clk)
    begin
        if (s3_done_reg && !cmd.phase)
            t_mem[cmd.i] <= sat;
        if (cmd.issue)
            t_rd_reg <= t_mem[cmd.k];
    end

    assign mul_a = s1_phase_reg ? t_rd_reg : k_rd_reg;
    assign sat   = scale_sat(acc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_done_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.issue;
            s2_valid_reg <= s1_valid_reg;
            s3_done_reg  <= s2_valid_reg && s2_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_phase_reg <= cmd.phase;
        s1_first_reg <= cmd.first;
        s1_last_reg  <= cmd.last_term;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        if (s1_valid_reg)
            prod_reg <= $signed(mul_a) * $signed(q_rd_reg);
        if (s2_valid_reg)
            acc_reg <= s2_first_reg ? prod_reg : acc_reg + prod_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s3_done_reg && cmd.phase)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s3_done_reg && cmd.phase)
        begin
            out_row_reg   <= cmd.j;
            out_col_reg   <= cmd.i;
            out_value_reg <= sat;
            out_last_reg  <= cmd.last_col;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.out_row   = out_row_reg;
    assign out_ch.out_col   = out_col_reg;
    assign out_ch.out_value = out_value_reg;
    assign out_ch.last      = out_last_reg;

    assign stat.sum_done = s3_done_reg;
    assign stat.out_busy = out_valid_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        s3_done_reg && cmd.phase |-> !out_valid_reg)
        else $error("result register overwritten");
    a_pipe_flow: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |=> s2_valid_reg)
        else $error("product stage lost a term");
    a_done_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        s3_done_reg |-> $past(s2_valid_reg && s2_last_reg))
        else $error("sum finished without final term");

endmodule
`default_nettype wire

// File: src/congruence_transform_qtkq.sv
`default_nettype none
// Congruence transform X = Q^T K Q, signed Q16.16, one shared multiply-accumulate unit.
// A compute row holds the input until its last sum is done: each sum issues n terms
// and then drains the MAC pipe, and each output sum first passes the output-wait state,
// where it stays while the output register is still held.
// rst_n (async, low) clears control state and sets dim_n = dim_m = 1; stores are not cleared.
module congruence_transform_qtkq
    import ctq_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    ctq_in_if.sink                in_ch,
    ctq_out_if.source             out_ch,
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [DIM_W-1:0] cfg_data
);

    // command and status between sequencer and datapath
    ctq_cmd_t  cmd;
    ctq_stat_t stat;

    // sequencer: takes transfers, holds dims, walks (i, k) loops
    ctq_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_ch.valid),
        .in_ready     (in_ch.ready),
        .in_operation (in_ch.operation),
        .in_row       (in_ch.row),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .stat         (stat),
        .cmd          (cmd)
    );

    // datapath: K, Q and temp memories, MAC pipe, saturation, output register
    ctq_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .ld_row   (in_ch.row),
        .ld_col   (in_ch.col),
        .ld_value (in_ch.value),
        .stat     (stat),
        .out_ch   (out_ch)
    );

endmodule
`default_nettype wire

// File: verif/congruence_transform_qtkq_tb.sv
`default_nettype none
module congruence_transform_qtkq_tb;
    import ctq_pkg::*;

    typedef struct {
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] value;
        logic              last;
    } x_entry_t;

    // Golden model of Q^T K Q: mirrors both stores and the dimension registers,
    // queues the row entries each compute transfer should produce.
    class congruence_board;
        int        k_mem [MAX_DIM*MAX_DIM];
        int        q_mem [MAX_DIM*MAX_DIM];
        int        dim_n = 1;
        int        dim_m = 1;
        x_entry_t  pending[$];
        int        errors = 0;

        function int clamp_dim(int d);
            if (d < 1)
                return 1;
            if (d > MAX_DIM)
                return MAX_DIM;
            return d;
        endfunction

        // arithmetic shift by the fraction width, then saturate to 32 bits
        function int rescale(longint acc);
            longint sh;
            sh = acc >>> FRAC_BITS;
            if (sh > 64'sd2147483647)
                return 32'h7fff_ffff;
            if (sh < -64'sd2147483648)
                return 32'h8000_0000;
            return int'(sh);
        endfunction

        // worst-case busy time of one compute row at the current dimensions
        function int row_cycles();
            int n;
            int m;
            n = clamp_dim(dim_n);
            m = clamp_dim(dim_m);
            return n * (n + 4) + m * (n + 5) + 64;
        endfunction

        function void note_input(ctq_op_t op, int r, int c, int v);
            int       n;
            int       m;
            int       tv [MAX_DIM];
            longint   acc;
            x_entry_t e;
            case (op)
                OP_LOAD_K: k_mem[r*MAX_DIM + c] = v;
                OP_LOAD_Q: q_mem[r*MAX_DIM + c] = v;
                OP_COMPUTE:
                begin
                    n = clamp_dim(dim_n);
                    m = clamp_dim(dim_m);
                    if (r < m)
                    begin
                        // temp = K^T * column r of Q
                        for (int i = 0; i < n; i++)
                        begin
                            acc = 0;
                            for (int k = 0; k < n; k++)
                                acc += longint'(k_mem[k*MAX_DIM + i]) *
                                       longint'(q_mem[k*MAX_DIM + r]);
                            tv[i] = rescale(acc);
                        end
                        for (int i = 0; i < m; i++)
                        begin
                            acc = 0;
                            for (int k = 0; k < n; k++)
                                acc += longint'(tv[k]) * longint'(q_mem[k*MAX_DIM + i]);
                            e.row   = IDX_W'(r);
                            e.col   = IDX_W'(i);
                            e.value = rescale(acc);
                            e.last  = (i == m - 1);
                            pending.push_back(e);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                                   logic [DATA_W-1:0] v, logic l);
            x_entry_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result row=%0d col=%0d value=%h", r, c, v);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (r !== e.row)
            begin
                $error("out_row: expected %0d, got %0d", e.row, r);
                errors++;
            end
            if (c !== e.col)
            begin
                $error("out_col: expected %0d, got %0d", e.col, c);
                errors++;
            end
            if (v !== e.value)
            begin
                $error("out_value: expected %h, got %h", e.value, v);
                errors++;
            end
            if (l !== e.last)
            begin
                $error("last: expected %b, got %b", e.last, l);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    ctq_reg_t cfg_index;
    logic [DIM_W-1:0] cfg_data;

    ctq_in_if  in_ch();
    ctq_out_if out_ch();

    congruence_transform_qtkq dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    congruence_board board = new();

    // idle mode: 0 = sender light / receiver heavy, 1 = swapped, 2 = no idling
    int  idle_mode = 0;
    int  hold_left = 0;
    bit  hold_req  = 0;
    longint cycle_count = 0;
    localparam longint CYCLE_LIMIT = 3_000_000;

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // timeout watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random backpressure plus one long hold-off on request;
    // every transfer is checked against the oldest queued entry
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            hold_left    <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
                board.check_result(out_ch.out_row, out_ch.out_col, out_ch.out_value,
                                   out_ch.last);
            if (hold_req && hold_left == 0)
            begin
                hold_left    <= 3000;
                out_ch.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left    <= hold_left - 1;
                out_ch.ready <= 1'b0;
            end
            else if (idle_mode == 0)
                out_ch.ready <= ($urandom_range(99) >= 69);
            else if (idle_mode == 1)
                out_ch.ready <= ($urandom_range(99) >= 11);
            else
                out_ch.ready <= 1'b1;
        end
    end

    // one input transfer, with an optional idle gap in front of it
    task automatic send(ctq_op_t op, int r, int c, int v);
        int pct;
        pct = (idle_mode == 0) ? 11 : (idle_mode == 1) ? 69 : 0;
        while ($urandom_range(99) < pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.row       <= IDX_W'(r);
        in_ch.col       <= IDX_W'(c);
        in_ch.value     <= v;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        board.note_input(op, r, c, v);
    endtask

    task automatic go_quiet();
        in_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // wait for every queued entry, then let a possibly silent compute finish
    task automatic drain();
        go_quiet();
        while (board.pending.size() != 0 || hold_left != 0)
            @(posedge clk);
        repeat (board.row_cycles())
            @(posedge clk);
    endtask

    task automatic write_reg(ctq_reg_t idx, int d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= DIM_W'(d);
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.dim_n = (idx == REG_DIM_N) ? d : board.dim_n;
        board.dim_m = (idx == REG_DIM_M) ? d : board.dim_m;
        @(posedge clk);
    endtask

    // half the time small Q16.16 numbers, otherwise extremes or full-range noise
    function automatic int pick_value();
        case ($urandom_range(7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2, 3: return $urandom;
            default: return $signed($urandom_range(32'h0006_0000)) - 32'sh0003_0000;
        endcase
    endfunction

    // configure, fill every entry the computes will read, then compute rows mixed with other items
    task automatic run_phase(int nd, int md, int computes);
        int n;
        int m;
        drain();
        write_reg(REG_DIM_N, nd);
        write_reg(REG_DIM_M, md);
        n = board.clamp_dim(nd);
        m = board.clamp_dim(md);
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                send(OP_LOAD_K, r, c, pick_value());
        for (int r = 0; r < n; r++)
            for (int c = 0; c < m; c++)
                send(OP_LOAD_Q, r, c, pick_value());
        for (int i = 0; i < computes; i++)
        begin
            case ($urandom_range(9))
                0: send(OP_NONE, $urandom_range(63), $urandom_range(63), $urandom);
                // loads outside the live region are stored but never read
                1: send(OP_LOAD_K, $urandom_range(63), 63, pick_value());
                2: send(OP_COMPUTE, $urandom_range(63), $urandom_range(63), $urandom);
                default: send(OP_COMPUTE, $urandom_range(m - 1), $urandom_range(63),
                              $urandom);
            endcase
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_DIM_N;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.operation = OP_LOAD_K;
        in_ch.row       = '0;
        in_ch.col       = '0;
        in_ch.value     = '0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: 1x1 with saturating extremes, an out-of-range row, unused op
        send(OP_LOAD_K, 0, 0, 32'h7fff_ffff);
        send(OP_LOAD_Q, 0, 0, 32'h8000_0000);
        send(OP_COMPUTE, 0, 0, 0);
        send(OP_COMPUTE, 5, 0, 0);
        send(OP_NONE, 63, 63, 32'hffff_ffff);
        send(OP_LOAD_Q, 0, 0, 32'h0001_0000);
        send(OP_LOAD_K, 0, 0, 32'hffff_0000);
        send(OP_COMPUTE, 0, 0, 0);
        // a zero dimension behaves as one
        run_phase(0, 2, 3);
        run_phase(2, 3, 4);

        // random phases under each idling pattern
        for (int mode = 0; mode < 3; mode++)
        begin
            drain();
            idle_mode = mode;
            run_phase($urandom_range(1, 4), $urandom_range(1, 4), 6);
        end

        // long receiver hold-off while computes keep coming
        drain();
        write_reg(REG_DIM_N, 3);
        write_reg(REG_DIM_M, 4);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 4; c++)
            begin
                send(OP_LOAD_K, r, c % 3, pick_value());
                send(OP_LOAD_Q, r, c, pick_value());
            end
        hold_req = 1;
        wait (hold_left != 0);
        hold_req = 0;
        for (int i = 0; i < 8; i++)
            send(OP_COMPUTE, $urandom_range(3), 0, 0);

        drain();
        if (board.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire

// File: files.f
src/ctq_pkg.sv
src/ctq_if.sv
src/ctq_ctrl.sv
src/ctq_dp.sv
src/congruence_transform_qtkq.sv
verif/congruence_transform_qtkq_tb.sv
